FILE: rtl/core/drmt_pkg.sv
// shared types and constants of the dirty rectangle merge table
package drmt_pkg;

   localparam int MAX_RECTS = 16;
   localparam int IDX_W     = $clog2(MAX_RECTS);
   localparam int CNT_W     = $clog2(MAX_RECTS + 1);

   // largest extent kept, wider inputs are clipped to this
   localparam logic [14:0] EXTENT_MAX = 15'd16384;

   typedef enum logic [1:0] {
      MODE_CLEAR = 2'd0,
      MODE_ADD   = 2'd1,
      MODE_FIND  = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_MISS   = 2'd1,
      STAT_FORCED = 2'd2
   } status_type;

   typedef struct packed {
      mode_type    mode;
      logic [13:0] rect_x;
      logic [13:0] rect_y;
      logic [14:0] rect_w;
      logic [14:0] rect_h;
      logic [3:0]  entry_index;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  found_index;
      logic [13:0] out_x;
      logic [13:0] out_y;
      logic [14:0] out_w;
      logic [14:0] out_h;
      logic [4:0]  entry_count;
      logic        overflow_seen;
   } rsp_type;

   // stored form: left/top plus exclusive right/bottom edge
   typedef struct packed {
      logic [13:0] x;
      logic [13:0] y;
      logic [14:0] r;
      logic [14:0] b;
   } box_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_SCAN_ADDR,
      ST_SCAN_CMP,
      ST_MOVE,
      ST_FORCE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      RD_SCAN,
      RD_LAST,
      RD_TOP,
      RD_INDEX
   } rd_sel_type;

   typedef enum logic [2:0] {
      RSP_CLEAR,
      RSP_MISS,
      RSP_RANGE,
      RSP_READ,
      RSP_FOUND,
      RSP_ADDED
   } rsp_kind_type;

   typedef struct packed {
      logic         load_req;
      logic         clear;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_move;
      logic         wr_append;
      logic         union_en;
      logic         scan_clr;
      logic         scan_inc;
      logic         count_dec;
      logic         force_merge;
      logic         rsp_load;
      rsp_kind_type rsp_kind;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     empty;
      logic     in_range;
      logic     scan_end;
      logic     hit;
      logic     full;
      logic     rsp_free;
   } stat_type;

endpackage

FILE: rtl/core/drmt_ctrl.sv
// sequencer for clear, add with merge scan, find and read
module drmt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  drmt_pkg::stat_type stat,
   output drmt_pkg::cmd_type  cmd
);
   import drmt_pkg::*;

   state_type    state_ff, state_in;
   rsp_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         kind_ff  <= RSP_CLEAR;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cmd          = '0;
      cmd.rd_sel   = RD_SCAN;
      cmd.rsp_kind = kind_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            unique case (stat.mode)
               MODE_CLEAR: begin
                  cmd.clear = 1'b1;
                  kind_in   = RSP_CLEAR;
                  state_in  = ST_FINISH;
               end
               MODE_ADD, MODE_FIND: begin
                  if (stat.empty) begin
                     kind_in  = RSP_MISS;
                     state_in = ST_FINISH;
                  end else begin
                     cmd.scan_clr = 1'b1;
                     state_in     = ST_SCAN_ADDR;
                  end
               end
               MODE_READ: begin
                  if (stat.in_range) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = RD_INDEX;
                     kind_in    = RSP_READ;
                  end else begin
                     kind_in = RSP_RANGE;
                  end
                  state_in = ST_FINISH;
               end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SCAN_ADDR: begin
            if (!stat.scan_end) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SCAN;
               state_in   = ST_SCAN_CMP;
            end else if (stat.mode == MODE_FIND) begin
               kind_in  = RSP_MISS;
               state_in = ST_FINISH;
            end else if (stat.full) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_TOP;
               state_in   = ST_FORCE;
            end else begin
               cmd.wr_append = 1'b1;
               kind_in       = RSP_ADDED;
               state_in      = ST_FINISH;
            end
         end
         ST_SCAN_CMP: begin
            if (!stat.hit) begin
               cmd.scan_inc = 1'b1;
               state_in     = ST_SCAN_ADDR;
            end else if (stat.mode == MODE_FIND) begin
               kind_in  = RSP_FOUND;
               state_in = ST_FINISH;
            end else begin
               cmd.union_en = 1'b1;
               cmd.rd_en    = 1'b1;
               cmd.rd_sel   = RD_LAST;
               state_in     = ST_MOVE;
            end
         end
         ST_MOVE: begin
            cmd.wr_move   = 1'b1;
            cmd.count_dec = 1'b1;
            cmd.scan_clr  = 1'b1;
            state_in      = ST_SCAN_ADDR;
         end
         ST_FORCE: begin
            cmd.union_en    = 1'b1;
            cmd.force_merge = 1'b1;
            cmd.scan_clr    = 1'b1;
            state_in        = ST_SCAN_ADDR;
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/core/drmt_datapath.sv
// rectangle table memory, working box, counters and result register
module drmt_datapath (
   input  logic               clock,
   input  logic               reset,
   input  drmt_pkg::req_type  req_data,
   input  drmt_pkg::cmd_type  cmd,
   output drmt_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output drmt_pkg::rsp_type  rsp_data
);
   import drmt_pkg::*;

   box_type mem [MAX_RECTS];

   req_type              req_ff;
   box_type              box_ff, box_in;
   box_type              rd_data_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic                 ovf_ff, ovf_in;
   logic                 forced_ff, forced_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [14:0]          w_sat, h_sat;
   logic [CNT_W-1:0]     count_m1;
   logic [IDX_W-1:0]     rd_addr;
   logic [IDX_W-1:0]     wr_addr;
   box_type              wr_data;
   box_type              out_box;

   function automatic logic boxes_meet(box_type a, box_type e);
      return ({1'b0, a.x} < e.r) && ({1'b0, e.x} < a.r) &&
             ({1'b0, a.y} < e.b) && ({1'b0, e.y} < a.b);
   endfunction

   function automatic box_type box_union(box_type a, box_type e);
      box_type u;
      u.x = (a.x < e.x) ? a.x : e.x;
      u.y = (a.y < e.y) ? a.y : e.y;
      u.r = (a.r > e.r) ? a.r : e.r;
      u.b = (a.b > e.b) ? a.b : e.b;
      return u;
   endfunction

   // clip oversized extents
   assign w_sat    = (req_data.rect_w > EXTENT_MAX) ? EXTENT_MAX : req_data.rect_w;
   assign h_sat    = (req_data.rect_h > EXTENT_MAX) ? EXTENT_MAX : req_data.rect_h;
   assign count_m1 = count_ff - CNT_W'(1);

   always_comb begin
      box_in = box_ff;
      if (cmd.load_req) begin
         box_in.x = req_data.rect_x;
         box_in.y = req_data.rect_y;
         box_in.r = {1'b0, req_data.rect_x} + w_sat;
         box_in.b = {1'b0, req_data.rect_y} + h_sat;
      end else if (cmd.union_en) begin
         box_in = box_union(box_ff, rd_data_ff);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.force_merge) begin
         count_in = CNT_W'(MAX_RECTS - 1);
      end else if (cmd.count_dec) begin
         count_in = count_m1;
      end else if (cmd.wr_append) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_clr) begin
         scan_in = '0;
      end else if (cmd.scan_inc) begin
         scan_in = scan_ff + CNT_W'(1);
      end
   end

   always_comb begin
      ovf_in = ovf_ff;
      if (cmd.clear) begin
         ovf_in = 1'b0;
      end else if (cmd.force_merge) begin
         ovf_in = 1'b1;
      end
   end

   always_comb begin
      forced_in = forced_ff;
      if (cmd.load_req) begin
         forced_in = 1'b0;
      end else if (cmd.force_merge) begin
         forced_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         scan_ff      <= '0;
         ovf_ff       <= 1'b0;
         forced_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         ovf_ff       <= ovf_in;
         forced_ff    <= forced_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      box_ff <= box_in;
      if (cmd.rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // table memory, one write and one registered read per cycle
   always_comb begin
      unique case (cmd.rd_sel)
         RD_SCAN:  rd_addr = scan_ff[IDX_W-1:0];
         RD_LAST:  rd_addr = count_m1[IDX_W-1:0];
         RD_TOP:   rd_addr = IDX_W'(MAX_RECTS - 1);
         RD_INDEX: rd_addr = IDX_W'(req_ff.entry_index);
         default:  rd_addr = scan_ff[IDX_W-1:0];
      endcase
   end

   assign wr_addr = cmd.wr_move ? scan_ff[IDX_W-1:0] : count_ff[IDX_W-1:0];
   assign wr_data = cmd.wr_move ? rd_data_ff : box_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_move || cmd.wr_append) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // status toward the sequencer
   assign stat.mode     = req_ff.mode;
   assign stat.empty    = (req_ff.rect_w == '0) || (req_ff.rect_h == '0);
   assign stat.in_range = int'(req_ff.entry_index) < int'(count_ff);
   assign stat.scan_end = scan_ff >= count_ff;
   assign stat.hit      = boxes_meet(box_ff, rd_data_ff);
   assign stat.full     = count_ff == CNT_W'(MAX_RECTS);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   // result assembly
   assign out_box = (cmd.rsp_kind == RSP_ADDED) ? box_ff : rd_data_ff;

   always_comb begin
      rsp_in               = '0;
      rsp_in.status        = STAT_OK;
      rsp_in.entry_count   = 5'(count_ff);
      rsp_in.overflow_seen = ovf_ff;
      case (cmd.rsp_kind)
         RSP_CLEAR: begin
         end
         RSP_MISS: begin
            rsp_in.status = STAT_MISS;
         end
         RSP_RANGE: begin
            rsp_in.status      = STAT_MISS;
            rsp_in.found_index = req_ff.entry_index;
         end
         RSP_READ, RSP_FOUND, RSP_ADDED: begin
            if (cmd.rsp_kind == RSP_READ) begin
               rsp_in.found_index = req_ff.entry_index;
            end else if (cmd.rsp_kind == RSP_FOUND) begin
               rsp_in.found_index = 4'(scan_ff);
            end else begin
               rsp_in.found_index = 4'(count_m1);
               rsp_in.status      = forced_ff ? STAT_FORCED : STAT_OK;
            end
            rsp_in.out_x = out_box.x;
            rsp_in.out_y = out_box.y;
            rsp_in.out_w = out_box.r - {1'b0, out_box.x};
            rsp_in.out_h = out_box.b - {1'b0, out_box.y};
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECTS))
      else $error("entry count above table size");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_append |-> count_ff < CNT_W'(MAX_RECTS))
      else $error("append into a full table");

   a_single_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.wr_move && cmd.wr_append))
      else $error("two table writes in one cycle");

   a_forced_sticky: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STAT_FORCED) |-> rsp_ff.overflow_seen)
      else $error("forced merge reported without overflow flag");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before transfer");
`endif

endmodule

FILE: rtl/core/dirty_rect_merge_table.sv
// dirty rectangle merge table: top level joining sequencer and datapath
// clear, read and ignored requests go from the start state straight to the finish state
// add and find walk the table entry by entry, an address state then a compare state per entry (registered table read)
// each merge passes through the move state and restarts the walk, a forced merge through the force state likewise
// next request taken only once the last result is registered
// reset: synchronous active high, empties the table and clears the overflow flag
module dirty_rect_merge_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  drmt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output drmt_pkg::rsp_type rsp_data
);
   import drmt_pkg::*;

   // command and status between sequencer and datapath
   cmd_type  cmd;
   stat_type stat;

   // sequencer: one request at a time, waits on the result register
   drmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: table memory, working box, counters, result register
   drmt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench of the dirty rectangle merge table
module tb_top;
   import drmt_pkg::*;

   // cycles without any transfer before the run is declared hung;
   // worst add walks a full table once per merge
   localparam int HANG_LIMIT   = 5000;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 20;

   // shadow copy of one table entry, left/top plus width/height
   typedef struct packed {
      logic [13:0] x;
      logic [13:0] y;
      logic [14:0] w;
      logic [14:0] h;
   } dirty_box_type;

   // tracks the table contents and checks every result against the oldest prediction
   class rect_merge_scoreboard;
      dirty_box_type boxes[MAX_RECTS];
      int unsigned   box_count;
      bit            overflow_flag;
      rsp_type       expected_rsp[$];
      int            mismatches;
      int            results_seen;

      function new();
         box_count     = 0;
         overflow_flag = 1'b0;
         mismatches    = 0;
         results_seen  = 0;
      endfunction

      // right and bottom are exclusive, so touching boxes do not overlap
      function bit overlapping(dirty_box_type a, dirty_box_type b);
         logic [15:0] a_right, b_right, a_bottom, b_bottom;
         a_right  = 16'(a.x) + 16'(a.w);
         b_right  = 16'(b.x) + 16'(b.w);
         a_bottom = 16'(a.y) + 16'(a.h);
         b_bottom = 16'(b.y) + 16'(b.h);
         return (a.x < b_right) && (b.x < a_right) && (a.y < b_bottom) && (b.y < a_bottom);
      endfunction

      function dirty_box_type bounding_box(dirty_box_type a, dirty_box_type b);
         dirty_box_type r;
         logic [15:0]   a_right, b_right, a_bottom, b_bottom, right, bottom;
         a_right  = 16'(a.x) + 16'(a.w);
         b_right  = 16'(b.x) + 16'(b.w);
         a_bottom = 16'(a.y) + 16'(a.h);
         b_bottom = 16'(b.y) + 16'(b.h);
         r.x      = (a.x < b.x) ? a.x : b.x;
         r.y      = (a.y < b.y) ? a.y : b.y;
         right    = (a_right > b_right) ? a_right : b_right;
         bottom   = (a_bottom > b_bottom) ? a_bottom : b_bottom;
         r.w      = 15'(right - 16'(r.x));
         r.h      = 15'(bottom - 16'(r.y));
         return r;
      endfunction

      // slot of the first stored box hit by q, or the count when none
      function int unsigned first_overlap(dirty_box_type q);
         for (int unsigned i = 0; i < box_count; i++) begin
            if (overlapping(q, boxes[i])) return i;
         end
         return box_count;
      endfunction

      function logic [14:0] clip_extent(logic [14:0] v);
         return (v > EXTENT_MAX) ? EXTENT_MAX : v;
      endfunction

      // apply one accepted request to the shadow table and queue its result
      function void accept_request(req_type r);
         rsp_type       e;
         dirty_box_type q;
         dirty_box_type hit_box;
         int unsigned   i;
         bit            scanning;
         e        = '0;
         e.status = STAT_OK;
         hit_box  = '0;
         q.x      = r.rect_x;
         q.y      = r.rect_y;
         q.w      = clip_extent(r.rect_w);
         q.h      = clip_extent(r.rect_h);
         case (r.mode)
            MODE_CLEAR: begin
               box_count     = 0;
               overflow_flag = 1'b0;
            end
            MODE_ADD: begin
               if (q.w == 0 || q.h == 0) begin
                  e.status = STAT_MISS;
               end else begin
                  scanning = 1'b1;
                  while (scanning) begin
                     i = first_overlap(q);
                     if (i < box_count) begin
                        // absorb the hit, backfill its slot with the last entry
                        q        = bounding_box(q, boxes[i]);
                        boxes[i] = boxes[box_count - 1];
                        box_count--;
                     end else if (box_count >= MAX_RECTS) begin
                        // full and disjoint: swallow the last entry and rescan
                        q             = bounding_box(q, boxes[MAX_RECTS - 1]);
                        box_count     = MAX_RECTS - 1;
                        overflow_flag = 1'b1;
                        e.status      = STAT_FORCED;
                     end else begin
                        scanning = 1'b0;
                     end
                  end
                  boxes[box_count] = q;
                  e.found_index    = box_count[3:0];
                  box_count++;
                  hit_box = q;
               end
            end
            MODE_FIND: begin
               e.status = STAT_MISS;
               if (q.w != 0 && q.h != 0) begin
                  i = first_overlap(q);
                  if (i < box_count) begin
                     e.status      = STAT_OK;
                     e.found_index = i[3:0];
                     hit_box       = boxes[i];
                  end
               end
            end
            MODE_READ: begin
               e.found_index = r.entry_index;
               if (r.entry_index < box_count) hit_box = boxes[r.entry_index];
               else e.status = STAT_MISS;
            end
         endcase
         e.out_x         = hit_box.x;
         e.out_y         = hit_box.y;
         e.out_w         = hit_box.w;
         e.out_h         = hit_box.h;
         e.entry_count   = box_count[4:0];
         e.overflow_seen = overflow_flag;
         expected_rsp    = {expected_rsp, e};
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: %s expected %0h got %0h", results_seen, name, want, got);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         results_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d: unexpected transfer %0h", results_seen, got);
            return;
         end
         e = expected_rsp.pop_front();
         compare_field("status",        32'(e.status),        32'(got.status));
         compare_field("found_index",   32'(e.found_index),   32'(got.found_index));
         compare_field("out_x",         32'(e.out_x),         32'(got.out_x));
         compare_field("out_y",         32'(e.out_y),         32'(got.out_y));
         compare_field("out_w",         32'(e.out_w),         32'(got.out_w));
         compare_field("out_h",         32'(e.out_h),         32'(got.out_h));
         compare_field("entry_count",   32'(e.entry_count),   32'(got.entry_count));
         compare_field("overflow_seen", 32'(e.overflow_seen), 32'(got.overflow_seen));
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rect_merge_scoreboard sb = new();

   // when set, both sides run back to back with no idle cycles
   bit quiet_phase = 1'b0;
   int useful_items;

   always #10 clock = ~clock;

   dirty_rect_merge_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   function int draw_gap();
      return quiet_phase ? 0 : $urandom_range(0, 4);
   endfunction

   function req_type make_req(mode_type m, int unsigned x, int unsigned y,
                              int unsigned w, int unsigned h, int unsigned idx);
      req_type r;
      r.mode        = m;
      r.rect_x      = x[13:0];
      r.rect_y      = y[13:0];
      r.rect_w      = w[14:0];
      r.rect_h      = h[14:0];
      r.entry_index = idx[3:0];
      return r;
   endfunction

   // small box on a 24 pixel grid, so most adds stay disjoint and the table fills up
   function req_type grid_req(mode_type m);
      int unsigned span;
      span = ($urandom_range(0, 4) == 0) ? 200 : 20;
      return make_req(m, $urandom_range(0, 15) * 24 + $urandom_range(0, 3),
                      $urandom_range(0, 15) * 24 + $urandom_range(0, 3),
                      $urandom_range(1, span), $urandom_range(1, span), 0);
   endfunction

   // one request transfer, the valid stays up across back-to-back items
   task send_request(req_type item);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.accept_request(item);
      if (item.mode == MODE_CLEAR || item.mode == MODE_READ ||
          (item.rect_w != 0 && item.rect_h != 0))
         useful_items++;
   endtask

   // run of disjoint adds, enough to overrun the table and force merges
   task fill_burst(int n);
      int unsigned base_x, base_y;
      base_x = $urandom_range(0, 2000);
      base_y = $urandom_range(0, 2000);
      for (int k = 0; k < n; k++)
         send_request(make_req(MODE_ADD, base_x + (k % 6) * 24 + $urandom_range(0, 3),
                               base_y + (k / 6) * 24 + $urandom_range(0, 3),
                               $urandom_range(1, 20), $urandom_range(1, 20), 0));
   endtask

   // result side: random stalls, every result transfer goes to the scoreboard
   initial begin
      int gap;
      wait (reset == 1'b0);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
      end
   end

   // hang detector: any cycle with a transfer on either side restarts the count
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < HANG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int pick;
      int next_phase;
      useful_items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: empty table corner cases first
      send_request(make_req(MODE_CLEAR, 0, 0, 0, 0, 0));
      send_request(make_req(MODE_ADD, 5, 5, 0, 9, 0));        // zero width is ignored
      send_request(make_req(MODE_ADD, 5, 5, 9, 0, 0));        // zero height is ignored
      send_request(make_req(MODE_FIND, 0, 0, 0, 7, 0));       // empty query
      send_request(make_req(MODE_READ, 0, 0, 0, 0, 0));       // read on an empty table
      // three boxes that only touch, none of them merge
      send_request(make_req(MODE_ADD, 0, 0, 10, 10, 0));
      send_request(make_req(MODE_ADD, 10, 0, 10, 10, 0));
      send_request(make_req(MODE_ADD, 0, 10, 10, 10, 0));
      send_request(make_req(MODE_FIND, 9, 9, 1, 1, 0));       // corner pixel of the first
      send_request(make_req(MODE_FIND, 20, 20, 5, 5, 0));     // just past all of them
      send_request(make_req(MODE_READ, 0, 0, 0, 0, 2));
      send_request(make_req(MODE_READ, 0, 0, 0, 0, 3));       // index at the count
      send_request(make_req(MODE_READ, 0, 0, 0, 0, 15));
      // overlaps all three, scan restarts after each merge
      send_request(make_req(MODE_ADD, 5, 5, 10, 10, 0));
      // far corner with oversized extents, clipped to the largest extent
      send_request(make_req(MODE_ADD, 16383, 16383, 32767, 32767, 0));
      // covers everything, giving the widest box the table can hold
      send_request(make_req(MODE_ADD, 0, 0, 16384, 16384, 0));
      send_request(make_req(MODE_READ, 0, 0, 0, 0, 0));
      send_request(make_req(MODE_FIND, 16383, 0, 16384, 1, 0));
      send_request(make_req(MODE_ADD, 0, 0, 16385, 1, 0));   // just over the clip point
      send_request(make_req(MODE_CLEAR, 0, 0, 0, 0, 0));
      send_request(make_req(MODE_READ, 0, 0, 0, 0, 0));       // cleared table reads as miss

      // overrun the table once straight away
      fill_burst(18);

      // random part: mostly grid boxes, with bursts, clears and raw noise mixed in
      useful_items = 0;
      next_phase   = 100;
      while (useful_items < RANDOM_ITEMS) begin
         if (useful_items >= next_phase) begin
            quiet_phase = ($urandom_range(0, 3) == 0);
            next_phase += 100;
         end
         pick = $urandom_range(0, 99);
         if (pick < 2)
            send_request(make_req(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom));
         else if (pick < 6)
            fill_burst($urandom_range(12, 20));
         else if (pick < 46)
            send_request(grid_req(MODE_ADD));
         else if (pick < 66)
            send_request(grid_req(MODE_FIND));
         else if (pick < 86)
            send_request(make_req(MODE_READ, 0, 0, 0, 0, $urandom_range(0, 15)));
         else
            // raw fields over their whole width, oversized extents included
            send_request(make_req(mode_type'($urandom_range(0, 3)), $urandom, $urandom,
                                  $urandom, $urandom, $urandom));
      end
      req_valid <= 1'b0;

      // drain outstanding results, then let the block settle
      while (sb.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/drmt_pkg.sv
rtl/core/drmt_ctrl.sv
rtl/core/drmt_datapath.sv
rtl/core/dirty_rect_merge_table.sv
tb/sv/tb_top.sv
